// File: sv/rlamf_pkg.sv
package rlamf_pkg;

  // Store geometry.
  localparam int unsigned DEPTH  = 64;
  localparam int unsigned CNT_W  = $clog2(DEPTH + 1);
  localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  // Arithmetic widths: the sum of DEPTH 32-bit values, then scaled by 256.
  localparam int unsigned VAL_W  = 32;
  localparam int unsigned SUM_W  = VAL_W + CNT_W;
  localparam int unsigned FRAC_W = 8;
  localparam int unsigned DVD_W  = SUM_W + FRAC_W;
  localparam int unsigned AVG_W  = 40;
  localparam int unsigned NUM_W  = 7;

  // Command codes.
  localparam logic [1:0] CMD_APPEND  = 2'd0;
  localparam logic [1:0] CMD_AVERAGE = 2'd1;
  localparam logic [1:0] CMD_REMOVE  = 2'd2;

  // Status codes.
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  typedef struct packed {
    logic [1:0]              cmd;
    logic signed [VAL_W-1:0] value;
  } in_t;

  typedef struct packed {
    logic [1:0]              status;
    logic signed [AVG_W-1:0] average;
    logic [NUM_W-1:0]        removed;
    logic [NUM_W-1:0]        count;
  } out_t;

endpackage

// File: sv/rlamf_store.sv
module rlamf_store
  import rlamf_pkg::*;
(
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [VAL_W-1:0]  wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [VAL_W-1:0]  rdata_o
);

  logic [VAL_W-1:0] mem_q [DEPTH];
  logic [VAL_W-1:0] rdata_q;

  // One write port and one registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: sv/rlamf_div.sv
module rlamf_div
  import rlamf_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic signed [DVD_W-1:0] dividend_i,
  input  logic [CNT_W-1:0]        divisor_i,
  output logic                    done_o,
  output logic signed [DVD_W-1:0] quotient_o
);

  localparam int unsigned STEP_W = $clog2(DVD_W + 1);

  logic              busy_q;
  logic              done_q;
  logic              neg_q;
  logic [STEP_W-1:0] step_q;
  logic [CNT_W-1:0]  div_q;
  logic [CNT_W-1:0]  rem_q;
  logic [DVD_W-1:0]  quo_q;

  logic [DVD_W-1:0]  mag;
  logic [CNT_W:0]    part;
  logic [CNT_W:0]    diff;
  logic              ge;

  // Magnitude of the dividend; the most negative value maps onto itself unsigned.
  assign mag = dividend_i[DVD_W-1] ? (~dividend_i + DVD_W'(1)) : dividend_i;

  // One restoring step: shift in the next dividend bit and try the subtract.
  assign part = {rem_q, quo_q[DVD_W-1]};
  assign diff = part - {1'b0, div_q};
  assign ge   = (part >= {1'b0, div_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= '0;
      end else if (busy_q) begin
        step_q <= step_q + STEP_W'(1);
        if (step_q == STEP_W'(DVD_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Datapath registers of the divider.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      neg_q <= dividend_i[DVD_W-1];
      div_q <= divisor_i;
      rem_q <= '0;
      quo_q <= mag;
    end else if (busy_q) begin
      rem_q <= ge ? diff[CNT_W-1:0] : part[CNT_W-1:0];
      quo_q <= {quo_q[DVD_W-2:0], ge};
    end
  end

  assign done_o     = done_q;
  assign quotient_o = neg_q ? signed'(~quo_q + DVD_W'(1)) : signed'(quo_q);

endmodule

// File: sv/ring_list_append_mean_filter_core.sv
// Ordered store of up to DEPTH signed 32-bit values, driven by commands.
// Input channel in_valid_i / in_stall_o carries one command beat (cmd, value);
// output channel out_valid_o / out_stall_i returns one result beat per command.
// Commands: append a value, take the mean of all values (times 256, truncated
// toward zero), or remove every value below a threshold while keeping order.
// Append, unknown and empty-store commands go straight to the result state;
// remove walks the n stored values, reading one entry per cycle through the
// registered store port; average walks them the same way to form the sum and
// then runs the one-bit-per-cycle divider over DVD_W (47 at DEPTH 64) quotient
// bits. Only one command is in flight: a new command is stalled until the
// previous one has placed its result and the block is idle again. A
// finished result sits in the output register, and the next command is taken
// while it waits. If the receiver stalls, the result beat holds and a later
// result waits in its final state until the register frees. Reset empties the
// store at once (count becomes zero); the store contents need no clearing pass.
module ring_list_append_mean_filter_core
  import rlamf_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  in_t  in_data_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output out_t out_data_o
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_SUM  = 5'b00010,
    S_DIV  = 5'b00100,
    S_REM  = 5'b01000,
    S_DONE = 5'b10000
  } state_e;

  state_e state_q, state_d;

  logic [CNT_W-1:0]        cnt_q, cnt_d;
  logic [CNT_W-1:0]        rd_q, rd_d;
  logic [CNT_W-1:0]        wr_q, wr_d;
  logic [CNT_W-1:0]        removed_q, removed_d;
  logic                    pend_q, pend_d;
  logic signed [SUM_W-1:0] sum_q, sum_d;
  logic signed [VAL_W-1:0] val_q, val_d;
  logic [1:0]              status_q, status_d;
  logic signed [AVG_W-1:0] avg_q, avg_d;
  logic                    out_valid_q, out_valid_d;
  out_t                    out_q, out_d;

  logic                    accept;
  logic                    out_free;
  logic                    issue;
  logic                    mem_we;
  logic [ADDR_W-1:0]       mem_waddr;
  logic [VAL_W-1:0]        mem_wdata;
  logic [VAL_W-1:0]        mem_rdata;
  logic                    div_start;
  logic                    div_done;
  logic signed [DVD_W-1:0] div_dividend;
  logic signed [DVD_W-1:0] div_quotient;

  assign accept   = in_valid_i && (state_q == S_IDLE);
  assign out_free = !out_valid_q || !out_stall_i;

  // A walk issues one read per cycle until every stored entry is requested.
  assign issue = ((state_q == S_SUM) || (state_q == S_REM)) && (rd_q < cnt_q);

  // Scale the final sum by 256 on its way into the divider.
  assign div_dividend = {sum_q, {FRAC_W{1'b0}}};

  // Command sequencer.
  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    rd_d        = rd_q;
    wr_d        = wr_q;
    removed_d   = removed_q;
    pend_d      = issue;
    sum_d       = sum_q;
    val_d       = val_q;
    status_d    = status_q;
    avg_d       = avg_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    mem_we      = 1'b0;
    mem_waddr   = cnt_q[ADDR_W-1:0];
    mem_wdata   = in_data_i.value;
    div_start   = 1'b0;

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    if (issue) begin
      rd_d = rd_q + CNT_W'(1);
    end

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          val_d     = in_data_i.value;
          status_d  = ST_OK;
          avg_d     = '0;
          removed_d = '0;
          rd_d      = '0;
          wr_d      = '0;
          sum_d     = '0;
          state_d   = S_DONE;
          if (in_data_i.cmd == CMD_APPEND) begin
            if (cnt_q >= CNT_W'(DEPTH)) begin
              status_d = ST_FULL;
            end else begin
              mem_we = 1'b1;
              cnt_d  = cnt_q + CNT_W'(1);
            end
          end else if ((in_data_i.cmd == CMD_AVERAGE) || (in_data_i.cmd == CMD_REMOVE)) begin
            if (cnt_q == '0) begin
              status_d = ST_EMPTY;
            end else if (in_data_i.cmd == CMD_AVERAGE) begin
              state_d = S_SUM;
            end else begin
              state_d = S_REM;
            end
          end
        end
      end

      S_SUM: begin
        if (pend_q) begin
          sum_d = sum_q + {{(SUM_W-VAL_W){mem_rdata[VAL_W-1]}}, mem_rdata};
        end else if (rd_q == cnt_q) begin
          div_start = 1'b1;
          state_d   = S_DIV;
        end
      end

      S_DIV: begin
        if (div_done) begin
          avg_d   = div_quotient[AVG_W-1:0];
          state_d = S_DONE;
        end
      end

      S_REM: begin
        if (pend_q) begin
          if (signed'(mem_rdata) < val_q) begin
            removed_d = removed_q + CNT_W'(1);
          end else begin
            mem_we    = 1'b1;
            mem_waddr = wr_q[ADDR_W-1:0];
            mem_wdata = mem_rdata;
            wr_d      = wr_q + CNT_W'(1);
          end
        end else if (rd_q == cnt_q) begin
          cnt_d   = wr_q;
          state_d = S_DONE;
        end
      end

      S_DONE: begin
        if (out_free) begin
          out_d.status  = status_q;
          out_d.average = avg_q;
          out_d.removed = NUM_W'(removed_q);
          out_d.count   = NUM_W'(cnt_q);
          out_valid_d   = 1'b1;
          state_d       = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      rd_q        <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      rd_q        <= rd_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    wr_q      <= wr_d;
    removed_q <= removed_d;
    sum_q     <= sum_d;
    val_q     <= val_d;
    status_q  <= status_d;
    avg_q     <= avg_d;
    out_q     <= out_d;
  end

  rlamf_store u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (issue),
    .raddr_i (rd_q[ADDR_W-1:0]),
    .rdata_o (mem_rdata)
  );

  rlamf_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (cnt_q),
    .done_o     (div_done),
    .quotient_o (div_quotient)
  );

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
